// ===== src/tw_pkg.sv =====
// ----------------------------------------------------------------------------
// tw_pkg
// Shared types, codes and defaults for the timing wheel refresh timer.
// ----------------------------------------------------------------------------
`default_nettype none

package tw_pkg;

  localparam int MAX_SLOTS_DEF  = 64;
  localparam int MAX_TIMERS_DEF = 64;
  localparam int SLOT_DEPTH_DEF = 32;

  localparam logic [6:0]  WHEEL_RESET = 7'd60;
  localparam logic [10:0] REF_LIMIT   = 11'd2047;

  localparam logic [1:0] CMD_ADD     = 2'd0;
  localparam logic [1:0] CMD_REFRESH = 2'd1;
  localparam logic [1:0] CMD_TICK    = 2'd2;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND    = 3'd1;
  localparam logic [2:0] ST_TABLE_FULL   = 3'd2;
  localparam logic [2:0] ST_SLOT_FULL    = 3'd3;
  localparam logic [2:0] ST_ALREADY_LIVE = 3'd4;
  localparam logic [2:0] ST_BAD_DELAY    = 3'd5;

  localparam logic KIND_ACK    = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] timer_key;
    logic [5:0]  delay;
  } request_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  status;
    logic [63:0] expired_key;
    logic        last;
  } result_t;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_REFRESH,
    OP_TICK,
    OP_NOP,
    OP_BAD_DELAY
  } job_op_t;

  typedef struct packed {
    job_op_t     op;
    logic [63:0] key;
    logic [5:0]  delay;
  } job_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_POST,
    S_LOAD,
    S_DIV,
    S_FRD,
    S_FILL,
    S_TSLOT,
    S_TREAD,
    S_TREF,
    S_TUPD,
    S_ACK
  } back_state_t;

endpackage

`default_nettype wire

// ===== src/tw_ram.sv =====
// ----------------------------------------------------------------------------
// tw_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   we,
  input  wire logic [AW-1:0]          waddr,
  input  wire logic [WIDTH-1:0]       wdata,
  input  wire logic [AW-1:0]          raddr,
  output logic      [WIDTH-1:0]       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/tw_front.sv =====
// ----------------------------------------------------------------------------
// tw_front
// Accepts requests, classifies them and queues jobs for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tw_front #(
  parameter int MAX_SLOTS = tw_pkg::MAX_SLOTS_DEF,
  localparam int CW = $clog2(MAX_SLOTS + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire tw_pkg::request_t  request,
  input  wire logic [CW-1:0]     eff_size,
  output logic                   q_valid,
  output tw_pkg::job_t           q_job,
  input  wire logic              q_pop
);

  localparam int XW = (CW > 6) ? CW : 6;

  tw_pkg::job_t mem [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  tw_pkg::job_t job_in;
  logic         push;
  logic         pop;

  always_comb begin
    job_in.key   = request.timer_key;
    job_in.delay = request.delay;
    case (request.command)
      tw_pkg::CMD_ADD: begin
        job_in.op = (XW'(request.delay) >= XW'(eff_size)) ? tw_pkg::OP_BAD_DELAY
                                                           : tw_pkg::OP_ADD;
      end
      tw_pkg::CMD_REFRESH: job_in.op = tw_pkg::OP_REFRESH;
      tw_pkg::CMD_TICK:    job_in.op = tw_pkg::OP_TICK;
      default:             job_in.op = tw_pkg::OP_NOP;
    endcase
  end

  assign busy    = (count == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (count != 2'd0);
  assign pop     = q_pop && q_valid;
  assign q_job   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= job_in;
    end
  end

endmodule

`default_nettype wire

// ===== src/tw_back.sv =====
// ----------------------------------------------------------------------------
// tw_back
// Sequencer that carries out queued jobs on the timer table and the wheel.
// ----------------------------------------------------------------------------
`default_nettype none

module tw_back #(
  parameter int MAX_SLOTS  = tw_pkg::MAX_SLOTS_DEF,
  parameter int MAX_TIMERS = tw_pkg::MAX_TIMERS_DEF,
  parameter int SLOT_DEPTH = tw_pkg::SLOT_DEPTH_DEF,
  localparam int CW = $clog2(MAX_SLOTS + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [CW-1:0]    eff_size,
  input  wire logic             q_valid,
  input  wire tw_pkg::job_t     q_job,
  output logic                  q_pop,
  output logic                  strobe,
  output tw_pkg::result_t       result
);

  localparam int SW  = $clog2(MAX_SLOTS);
  localparam int TW  = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int EIW = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
  localparam int FW  = $clog2(SLOT_DEPTH + 1);
  localparam int DW  = ((SW > 6) ? SW : 6) + 1;
  localparam int NW  = $clog2(DW + 1);
  localparam int ED  = MAX_SLOTS * (1 << EIW);

  tw_pkg::back_state_t state, state_next;

  tw_pkg::job_t          job;
  logic [2:0]            status;
  logic [TW:0]           scan_cnt;
  logic [TW-1:0]         prev_idx;
  logic                  prev_v;
  logic                  found;
  logic                  free_found;
  logic [TW-1:0]         hit_idx;
  logic [TW-1:0]         free_idx;
  logic [TW-1:0]         tidx;
  logic [10:0]           refs_hold;
  logic [DW-1:0]         dividend;
  logic [CW-1:0]         rem;
  logic [CW-1:0]         rem_next;
  logic [CW:0]           rem_sh;
  logic [NW-1:0]         div_cnt;
  logic [SW-1:0]         pos;
  logic [SW-1:0]         current;
  logic [FW-1:0]         tcnt;
  logic [FW-1:0]         titer;
  logic [MAX_TIMERS-1:0] live;
  logic [MAX_SLOTS-1:0]  fvalid;

  logic                  key_we;
  logic [TW-1:0]         key_raddr;
  logic [63:0]           key_rdata;
  logic                  delay_we;
  logic [5:0]            delay_rdata;
  logic                  refs_we;
  logic [10:0]           refs_wdata;
  logic [TW-1:0]         info_raddr;
  logic [10:0]           refs_rdata;
  logic                  ent_we;
  logic [SW+EIW-1:0]     ent_waddr;
  logic [SW+EIW-1:0]     ent_raddr;
  logic [TW-1:0]         ent_rdata;
  logic                  fill_we;
  logic [FW-1:0]         fill_wdata;
  logic [FW-1:0]         fill_rdata;
  logic [FW-1:0]         fill_cur;
  logic                  fill_full;
  logic                  scan_hit;
  logic                  scan_free;
  logic [10:0]           refs_dec;
  logic                  is_add;

  assign is_add    = (job.op == tw_pkg::OP_ADD);
  assign fill_cur  = fvalid[pos] ? fill_rdata : '0;
  assign fill_full = (fill_cur >= FW'(SLOT_DEPTH));
  assign scan_hit  = prev_v && live[prev_idx] && (key_rdata == job.key);
  assign scan_free = prev_v && !live[prev_idx];
  assign refs_dec  = (refs_rdata != 11'd0) ? refs_rdata - 11'd1 : 11'd0;
  assign ent_waddr = {pos, fill_cur[EIW-1:0]};
  assign ent_raddr = {pos, titer[EIW-1:0]};
  assign fill_wdata = fill_cur + FW'(1);

  always_comb begin
    rem_sh = {rem, dividend[DW-1]};
    if (rem_sh >= {1'b0, eff_size}) begin
      rem_sh = rem_sh - {1'b0, eff_size};
    end
    rem_next = rem_sh[CW-1:0];
  end

  tw_ram #(.WIDTH(64), .DEPTH(MAX_TIMERS)) u_keys (
    .clk(clk), .we(key_we), .waddr(tidx), .wdata(job.key),
    .raddr(key_raddr), .rdata(key_rdata)
  );

  tw_ram #(.WIDTH(6), .DEPTH(MAX_TIMERS)) u_delays (
    .clk(clk), .we(delay_we), .waddr(tidx), .wdata(job.delay),
    .raddr(info_raddr), .rdata(delay_rdata)
  );

  tw_ram #(.WIDTH(11), .DEPTH(MAX_TIMERS)) u_refs (
    .clk(clk), .we(refs_we), .waddr(tidx), .wdata(refs_wdata),
    .raddr(info_raddr), .rdata(refs_rdata)
  );

  tw_ram #(.WIDTH(TW), .DEPTH(ED)) u_entries (
    .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(tidx),
    .raddr(ent_raddr), .rdata(ent_rdata)
  );

  tw_ram #(.WIDTH(FW), .DEPTH(MAX_SLOTS)) u_fill (
    .clk(clk), .we(fill_we), .waddr(pos), .wdata(fill_wdata),
    .raddr(rem[SW-1:0]), .rdata(fill_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tw_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    key_we     = 1'b0;
    delay_we   = 1'b0;
    refs_we    = 1'b0;
    refs_wdata = is_add ? 11'd1 : refs_hold + 11'd1;
    ent_we     = 1'b0;
    fill_we    = 1'b0;
    key_raddr  = (state == tw_pkg::S_SCAN) ? scan_cnt[TW-1:0] : ent_rdata;
    info_raddr = (state == tw_pkg::S_POST) ? hit_idx : ent_rdata;
    case (state)
      tw_pkg::S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_job.op)
            tw_pkg::OP_ADD, tw_pkg::OP_REFRESH: state_next = tw_pkg::S_SCAN;
            tw_pkg::OP_TICK:                    state_next = tw_pkg::S_DIV;
            default:                            state_next = tw_pkg::S_ACK;
          endcase
        end
      end
      tw_pkg::S_SCAN: begin
        if (prev_v && prev_idx == TW'(MAX_TIMERS - 1)) begin
          state_next = tw_pkg::S_POST;
        end
      end
      tw_pkg::S_POST: begin
        if (is_add) begin
          state_next = (found || !free_found) ? tw_pkg::S_ACK : tw_pkg::S_LOAD;
        end else begin
          state_next = found ? tw_pkg::S_LOAD : tw_pkg::S_ACK;
        end
      end
      tw_pkg::S_LOAD: begin
        if (!is_add && refs_rdata >= tw_pkg::REF_LIMIT) begin
          state_next = tw_pkg::S_ACK;
        end else begin
          state_next = tw_pkg::S_DIV;
        end
      end
      tw_pkg::S_DIV: begin
        if (div_cnt == NW'(DW - 1)) begin
          state_next = tw_pkg::S_FRD;
        end
      end
      tw_pkg::S_FRD: begin
        state_next = (job.op == tw_pkg::OP_TICK) ? tw_pkg::S_TSLOT : tw_pkg::S_FILL;
      end
      tw_pkg::S_FILL: begin
        if (!fill_full) begin
          ent_we   = 1'b1;
          fill_we  = 1'b1;
          refs_we  = 1'b1;
          key_we   = is_add;
          delay_we = is_add;
        end
        state_next = tw_pkg::S_ACK;
      end
      tw_pkg::S_TSLOT: state_next = tw_pkg::S_TREAD;
      tw_pkg::S_TREAD: begin
        state_next = (titer >= tcnt) ? tw_pkg::S_ACK : tw_pkg::S_TREF;
      end
      tw_pkg::S_TREF: state_next = tw_pkg::S_TUPD;
      tw_pkg::S_TUPD: begin
        refs_wdata = refs_dec;
        refs_we    = live[tidx];
        state_next = tw_pkg::S_TREAD;
      end
      tw_pkg::S_ACK: state_next = tw_pkg::S_IDLE;
      default: state_next = tw_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live    <= '0;
      fvalid  <= '0;
      current <= '0;
      strobe  <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        tw_pkg::S_FRD: begin
          if (job.op == tw_pkg::OP_TICK) begin
            current <= rem[SW-1:0];
          end
        end
        tw_pkg::S_FILL: begin
          if (!fill_full) begin
            fvalid[pos] <= 1'b1;
            if (is_add) begin
              live[tidx] <= 1'b1;
            end
          end
        end
        tw_pkg::S_TSLOT: fvalid[pos] <= 1'b0;
        tw_pkg::S_TUPD: begin
          if (live[tidx] && refs_dec == 11'd0) begin
            live[tidx] <= 1'b0;
            strobe     <= 1'b1;
          end
        end
        tw_pkg::S_ACK: strobe <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      tw_pkg::S_IDLE: begin
        job        <= q_job;
        status     <= (q_job.op == tw_pkg::OP_BAD_DELAY) ? tw_pkg::ST_BAD_DELAY
                                                          : tw_pkg::ST_OK;
        scan_cnt   <= '0;
        prev_v     <= 1'b0;
        found      <= 1'b0;
        free_found <= 1'b0;
        div_cnt    <= '0;
        rem        <= '0;
        dividend   <= DW'(current) + DW'(1);
      end
      tw_pkg::S_SCAN: begin
        if (scan_cnt < (TW + 1)'(MAX_TIMERS)) begin
          prev_idx <= scan_cnt[TW-1:0];
          prev_v   <= 1'b1;
          scan_cnt <= scan_cnt + 1'b1;
        end else begin
          prev_v <= 1'b0;
        end
        if (scan_hit && !found) begin
          found   <= 1'b1;
          hit_idx <= prev_idx;
        end
        if (scan_free && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= prev_idx;
        end
      end
      tw_pkg::S_POST: begin
        tidx <= is_add ? free_idx : hit_idx;
        if (is_add) begin
          if (found) begin
            status <= tw_pkg::ST_ALREADY_LIVE;
          end else if (!free_found) begin
            status <= tw_pkg::ST_TABLE_FULL;
          end
        end else if (!found) begin
          status <= tw_pkg::ST_NOT_FOUND;
        end
      end
      tw_pkg::S_LOAD: begin
        refs_hold <= refs_rdata;
        dividend  <= DW'(current) + DW'(is_add ? job.delay : delay_rdata);
        if (!is_add && refs_rdata >= tw_pkg::REF_LIMIT) begin
          status <= tw_pkg::ST_SLOT_FULL;
        end
      end
      tw_pkg::S_DIV: begin
        rem      <= rem_next;
        dividend <= dividend << 1;
        div_cnt  <= div_cnt + 1'b1;
      end
      tw_pkg::S_FRD: pos <= rem[SW-1:0];
      tw_pkg::S_FILL: begin
        if (fill_full) begin
          status <= tw_pkg::ST_SLOT_FULL;
        end
      end
      tw_pkg::S_TSLOT: begin
        tcnt  <= fill_cur;
        titer <= '0;
      end
      tw_pkg::S_TREF: tidx <= ent_rdata;
      tw_pkg::S_TUPD: begin
        titer              <= titer + 1'b1;
        result.kind        <= tw_pkg::KIND_EXPIRY;
        result.status      <= tw_pkg::ST_OK;
        result.expired_key <= key_rdata;
        result.last        <= 1'b0;
      end
      tw_pkg::S_ACK: begin
        result.kind        <= tw_pkg::KIND_ACK;
        result.status      <= status;
        result.expired_key <= '0;
        result.last        <= 1'b1;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/timing_wheel_refresh_timer.sv =====
// ----------------------------------------------------------------------------
// timing_wheel_refresh_timer
// Timing wheel of idle timeouts with add, refresh and tick requests.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; up to two requests
// queue while the sequencer works. Every request ends in one acknowledgement
// with last set; a tick first gives one expiry notice per expired timer.
// Results appear for one cycle on result with strobe and cannot be held off.
// Add and refresh run a key search through the timer key memory, one entry
// a cycle. A tick walks every reference stored in the new slot. Write
// wheel_size only while no request is outstanding.
`default_nettype none

module timing_wheel_refresh_timer #(
  parameter int MAX_SLOTS  = tw_pkg::MAX_SLOTS_DEF,
  parameter int MAX_TIMERS = tw_pkg::MAX_TIMERS_DEF,
  parameter int SLOT_DEPTH = tw_pkg::SLOT_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire tw_pkg::request_t  request,
  input  wire logic              wheel_size_we,
  input  wire logic [6:0]        wheel_size,
  output logic                   strobe,
  output tw_pkg::result_t        result
);

  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int XW = (CW > 7) ? CW : 7;

  logic [6:0]    size_cfg;
  logic [CW-1:0] eff_size;
  logic          q_valid;
  logic          q_pop;
  tw_pkg::job_t  q_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_cfg <= tw_pkg::WHEEL_RESET;
    end else if (wheel_size_we) begin
      size_cfg <= wheel_size;
    end
  end

  always_comb begin
    if (XW'(size_cfg) < XW'(2)) begin
      eff_size = CW'(2);
    end else if (XW'(size_cfg) > XW'(MAX_SLOTS)) begin
      eff_size = CW'(MAX_SLOTS);
    end else begin
      eff_size = CW'(size_cfg);
    end
  end

  tw_front #(.MAX_SLOTS(MAX_SLOTS)) u_front (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .eff_size(eff_size), .q_valid(q_valid), .q_job(q_job), .q_pop(q_pop)
  );

  tw_back #(
    .MAX_SLOTS(MAX_SLOTS), .MAX_TIMERS(MAX_TIMERS), .SLOT_DEPTH(SLOT_DEPTH)
  ) u_back (
    .clk(clk), .rst(rst), .eff_size(eff_size), .q_valid(q_valid),
    .q_job(q_job), .q_pop(q_pop), .strobe(strobe), .result(result)
  );

endmodule

`default_nettype wire

// ===== sim/tb_timing_wheel_refresh_timer.sv =====
// ----------------------------------------------------------------------------
// tb_timing_wheel_refresh_timer
// Self-checking bench for the timing wheel refresh timer. A scoreboard keeps
// its own copy of the timer table and wheel and predicts every expiry notice
// and acknowledgement. Directed requests cover key and delay extremes, bad
// delays, duplicate and unknown keys, the unused command, a full slot and a
// full table. Random add/refresh/tick traffic then runs under several wheel
// sizes, including the clamped ones, with random gaps on the request side.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class wheel_scoreboard;
  int unsigned size_reg;
  int cur;
  int fill [64];
  int entries [64][32];
  bit live [64];
  logic [63:0] keys [64];
  int delays [64];
  int refs [64];
  tw_pkg::result_t expected_results [$];
  int errors;
  int expiries;
  int acks;

  function new();
    size_reg = tw_pkg::WHEEL_RESET;
    cur = 0;
    errors = 0;
    expiries = 0;
    acks = 0;
    foreach (fill[i]) fill[i] = 0;
    foreach (live[i]) live[i] = 0;
  endfunction

  function int wheel_len();
    if (size_reg < 2) return 2;
    if (size_reg > 64) return 64;
    return size_reg;
  endfunction

  function int find_timer(logic [63:0] key);
    for (int t = 0; t < 64; t++)
      if (live[t] && keys[t] == key) return t;
    return -1;
  endfunction

  function int live_count();
    int n;
    n = 0;
    foreach (live[i]) n += live[i];
    return n;
  endfunction

  function logic [63:0] pick_live_key();
    int t;
    t = $urandom_range(63);
    for (int i = 0; i < 64; i++)
      if (live[(t + i) % 64]) return keys[(t + i) % 64];
    return {$urandom, $urandom};
  endfunction

  function void note_request(tw_pkg::request_t r);
    logic [2:0] st;
    tw_pkg::result_t res;
    int t, pos, n;
    st = tw_pkg::ST_OK;
    if (r.command == tw_pkg::CMD_ADD) begin
      t = -1;
      if (r.delay >= wheel_len()) st = tw_pkg::ST_BAD_DELAY;
      else if (find_timer(r.timer_key) >= 0) st = tw_pkg::ST_ALREADY_LIVE;
      else begin
        for (int i = 63; i >= 0; i--) if (!live[i]) t = i;
        if (t < 0) st = tw_pkg::ST_TABLE_FULL;
        else begin
          pos = (cur + r.delay) % wheel_len();
          if (fill[pos] >= 32) st = tw_pkg::ST_SLOT_FULL;
          else begin
            entries[pos][fill[pos]] = t;
            fill[pos]++;
            live[t] = 1;
            keys[t] = r.timer_key;
            delays[t] = r.delay;
            refs[t] = 1;
          end
        end
      end
    end else if (r.command == tw_pkg::CMD_REFRESH) begin
      t = find_timer(r.timer_key);
      if (t < 0) st = tw_pkg::ST_NOT_FOUND;
      else if (refs[t] >= tw_pkg::REF_LIMIT) st = tw_pkg::ST_SLOT_FULL;
      else begin
        pos = (cur + delays[t]) % wheel_len();
        if (fill[pos] >= 32) st = tw_pkg::ST_SLOT_FULL;
        else begin
          entries[pos][fill[pos]] = t;
          fill[pos]++;
          refs[t]++;
        end
      end
    end else if (r.command == tw_pkg::CMD_TICK) begin
      cur = (cur + 1) % wheel_len();
      n = fill[cur];
      for (int i = 0; i < n; i++) begin
        t = entries[cur][i];
        if (live[t]) begin
          if (refs[t] > 0) refs[t]--;
          if (refs[t] == 0) begin
            live[t] = 0;
            res.kind = tw_pkg::KIND_EXPIRY;
            res.status = tw_pkg::ST_OK;
            res.expired_key = keys[t];
            res.last = 1'b0;
            expected_results = {expected_results, res};
          end
        end
      end
      fill[cur] = 0;
    end
    res.kind = tw_pkg::KIND_ACK;
    res.status = st;
    res.expired_key = '0;
    res.last = 1'b1;
    expected_results = {expected_results, res};
  endfunction

  task report_mismatch(string what);
    errors++;
    $display("MISMATCH @%0t: %s", $time, what);
  endtask

  task check_result(tw_pkg::result_t got);
    tw_pkg::result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result %p", got));
      return;
    end
    want = expected_results.pop_front();
    if (got.kind == tw_pkg::KIND_EXPIRY) expiries++; else acks++;
    if (got.kind !== want.kind || got.status !== want.status ||
        got.expired_key !== want.expired_key || got.last !== want.last)
      report_mismatch($sformatf("got %p want %p", got, want));
  endtask
endclass

module tb_timing_wheel_refresh_timer;
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  tw_pkg::request_t request = '0;
  logic wheel_size_we = 1'b0;
  logic [6:0] wheel_size = tw_pkg::WHEEL_RESET;
  logic strobe;
  tw_pkg::result_t result;

  wheel_scoreboard sb = new();
  int unsigned cycles = 0;
  int sent = 0;

  localparam int unsigned CYCLE_LIMIT = 1000000;

  timing_wheel_refresh_timer DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .wheel_size_we(wheel_size_we), .wheel_size(wheel_size),
    .strobe(strobe), .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && strobe) sb.check_result(result);
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task send(logic [1:0] cmd, logic [63:0] key, logic [5:0] dly);
    logic taken;
    start = 1'b1;
    request.command = cmd;
    request.timer_key = key;
    request.delay = dly;
    do begin
      taken = !busy;
      @(posedge clk);
      if (taken) sb.note_request(request);
      @(negedge clk);
    end while (!taken);
    sent++;
  endtask

  task pause_random();
    int n;
    n = ($urandom_range(99) < 5) ? $urandom_range(60, 20) :
        ($urandom_range(99) < 50) ? 0 : $urandom_range(3, 1);
    if (n > 0) begin
      start = 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task drain();
    start = 1'b0;
    while (sb.expected_results.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  task set_wheel(logic [6:0] v);
    drain();
    wheel_size_we = 1'b1;
    wheel_size = v;
    @(negedge clk);
    wheel_size_we = 1'b0;
    sb.size_reg = v;
  endtask

  task random_traffic(int count);
    int c;
    logic [63:0] key;
    logic [5:0] dly;
    for (int i = 0; i < count; i++) begin
      c = $urandom_range(99);
      dly = ($urandom_range(9) == 0) ? 6'($urandom) :
            6'($urandom_range(sb.wheel_len() - 1));
      if (c < 38) begin
        key = ($urandom_range(9) == 0 && sb.live_count() > 0) ?
              sb.pick_live_key() : {$urandom, $urandom};
        send(tw_pkg::CMD_ADD, key, dly);
      end else if (c < 72) begin
        key = ($urandom_range(9) < 8) ? sb.pick_live_key() : {$urandom, $urandom};
        send(tw_pkg::CMD_REFRESH, key, dly);
      end else if (c < 96) begin
        send(tw_pkg::CMD_TICK, {$urandom, $urandom}, dly);
      end else begin
        send(2'd3, {$urandom, $urandom}, dly);
      end
      pause_random();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // directed, reset wheel size
    send(tw_pkg::CMD_ADD, 64'h0, 6'd0);
    send(tw_pkg::CMD_ADD, '1, 6'd59);
    send(tw_pkg::CMD_ADD, 64'h1234, 6'd60);
    send(tw_pkg::CMD_ADD, 64'h5678, 6'd63);
    send(tw_pkg::CMD_ADD, 64'h0, 6'd5);
    send(tw_pkg::CMD_REFRESH, '1, 6'd0);
    send(tw_pkg::CMD_REFRESH, 64'hdead_beef, 6'd0);
    send(2'd3, '1, '1);
    send(tw_pkg::CMD_ADD, 64'h5555_5555_5555_5555, 6'd1);
    send(tw_pkg::CMD_TICK, '0, '0);
    send(tw_pkg::CMD_TICK, '0, '0);
    send(tw_pkg::CMD_REFRESH, 64'h5555_5555_5555_5555, 6'd0);

    // smallest wheel: full slot, then full table, then one big expiry burst
    set_wheel(7'd2);
    for (int i = 0; i < 33; i++) send(tw_pkg::CMD_ADD, {32'hA000_0000, 32'(i)}, 6'd1);
    for (int i = 0; i < 34; i++) send(tw_pkg::CMD_ADD, {32'hB000_0000, 32'(i)}, 6'd0);
    send(tw_pkg::CMD_ADD, 64'hC0, 6'd2);
    send(tw_pkg::CMD_TICK, '0, '0);
    send(tw_pkg::CMD_TICK, '0, '0);
    send(tw_pkg::CMD_TICK, '0, '0);

    set_wheel(7'd64);
    random_traffic(60);
    set_wheel(7'd127);
    random_traffic(55);
    set_wheel(7'd0);
    random_traffic(50);
    set_wheel(7'd1);
    random_traffic(45);
    set_wheel(7'($urandom_range(63, 3)));
    random_traffic(60);
    set_wheel(7'd60);
    random_traffic(55);
    set_wheel(7'd5);
    random_traffic(52);

    drain();
    $display("covered %0d requests over wheel sizes 0..127 incl. clamped ones,", sent);
    $display("%0d acknowledgements and %0d expiry notices checked", sb.acks, sb.expiries);
    if (sb.errors == 0 && sb.expected_results.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule

// ===== filelist.f =====
src/tw_pkg.sv
src/tw_ram.sv
src/tw_front.sv
src/tw_back.sv
src/timing_wheel_refresh_timer.sv
sim/tb_timing_wheel_refresh_timer.sv
